@@ design/raf_pkg.sv @@
`timescale 1ns / 1ps

package raf_pkg;

	localparam int MAX_PACKET   = 4096;
	localparam int HEADER_BYTES = 20;

	localparam int CNT_W    = $clog2(MAX_PACKET + 2);
	localparam int OFF_W    = 12;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] CNT_HDR_LAST = CNT_W'(HEADER_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_HDR      = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(MAX_PACKET);

	localparam logic [BYTE_W-1:0] TLV_HDR_LEN = BYTE_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_SKIP = 1'd1;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_MALFORMED = 2'd2,
		ST_SHORT     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_TYPE   = 4'b0010,
		PH_LEN    = 4'b0100,
		PH_VALUE  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} step_t;

	typedef struct packed {
		status_t           status;
		logic [OFF_W-1:0]  offset;
		logic [BYTE_W-1:0] length;
	} res_t;

endpackage

@@ design/raf_walk.sv @@
`timescale 1ns / 1ps

module raf_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  raf_pkg::step_t             step,
	input  logic [raf_pkg::BYTE_W-1:0] match_type,
	input  logic [raf_pkg::BYTE_W-1:0] match_skip,
	output raf_pkg::res_t              res
);
	import raf_pkg::*;

	logic [CNT_W-1:0]  byte_count_q, byte_count_d;
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0] skips_left_q, skips_left_d;
	logic              cur_match_q, cur_match_d;
	status_t           outcome_q, outcome_d;
	logic [OFF_W-1:0]  found_off_q, found_off_d;
	logic [BYTE_W-1:0] found_len_q, found_len_d;

	logic [CNT_W-1:0]  p;
	logic [CNT_W-1:0]  p_inc;
	logic [CNT_W-1:0]  len;
	logic [BYTE_W-1:0] skips;
	logic [BYTE_W-1:0] vlen;
	logic              cm;

	always_comb begin
		p     = byte_count_q;
		p_inc = p + CNT_W'(1);
		skips = (p == '0) ? match_skip : skips_left_q;
		vlen  = step.data - TLV_HDR_LEN;

		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		skips_left_d = skips;
		cur_match_d  = cur_match_q;
		outcome_d    = outcome_q;
		found_off_d  = found_off_q;
		found_len_d  = found_len_q;
		cm           = cur_match_q;

		if (outcome_q == ST_NOT_FOUND) begin
			case (phase_q)
				PH_HEADER: begin
					if (p >= CNT_HDR_LAST)
						phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					cur_match_d = (step.data == match_type);
					phase_d     = PH_LEN;
				end
				PH_LEN: begin
					if (step.data < TLV_HDR_LEN) begin
						outcome_d = ST_MALFORMED;
					end else begin
						if (cm && skips != '0) begin
							skips_left_d = skips - BYTE_W'(1);
							cm           = 1'b0;
						end
						cur_match_d = cm;
						if (cm) begin
							found_off_d = p_inc[OFF_W-1:0];
							found_len_d = vlen;
						end
						bytes_left_d = vlen;
						if (vlen == '0) begin
							if (cm)
								outcome_d = ST_FOUND;
							phase_d = PH_TYPE;
						end else begin
							phase_d = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					bytes_left_d = bytes_left_q - BYTE_W'(1);
					if (bytes_left_d == '0) begin
						if (cur_match_q)
							outcome_d = ST_FOUND;
						phase_d = PH_TYPE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end

		// byte count saturates one past the largest legal packet
		byte_count_d = (p <= CNT_MAX) ? p_inc : p;
		len          = byte_count_d;

		res.offset = '0;
		res.length = '0;
		if (len < CNT_HDR) begin
			res.status = ST_SHORT;
		end else if (len > CNT_MAX) begin
			res.status = ST_MALFORMED;
		end else if (outcome_d == ST_FOUND) begin
			res.status = ST_FOUND;
			res.offset = found_off_d;
			res.length = found_len_d;
		end else if (outcome_d == ST_MALFORMED) begin
			res.status = ST_MALFORMED;
		end else if (phase_d == PH_TYPE) begin
			res.status = ST_NOT_FOUND;
		end else begin
			res.status = ST_MALFORMED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			phase_q      <= PH_HEADER;
			bytes_left_q <= '0;
			skips_left_q <= '0;
			cur_match_q  <= 1'b0;
			outcome_q    <= ST_NOT_FOUND;
			found_off_q  <= '0;
			found_len_q  <= '0;
		end else if (step.valid) begin
			if (step.last) begin
				// rearm for the next packet
				byte_count_q <= '0;
				phase_q      <= PH_HEADER;
				bytes_left_q <= '0;
				skips_left_q <= match_skip;
				cur_match_q  <= 1'b0;
				outcome_q    <= ST_NOT_FOUND;
				found_off_q  <= '0;
				found_len_q  <= '0;
			end else begin
				byte_count_q <= byte_count_d;
				phase_q      <= phase_d;
				bytes_left_q <= bytes_left_d;
				skips_left_q <= skips_left_d;
				cur_match_q  <= cur_match_d;
				outcome_q    <= outcome_d;
				found_off_q  <= found_off_d;
				found_len_q  <= found_len_d;
			end
		end
	end

endmodule

@@ design/radius_attribute_finder_top.sv @@
`timescale 1ns / 1ps

// Attribute finder for RADIUS-style packets.
//
// Input channel (in_valid / in_stall / data_byte / last_byte): one packet
// octet per transaction, last_byte set on the final octet. The fixed header
// is skipped, then the type-length-value list is walked looking for the
// instance of match_type that follows match_skip earlier ones.
// Output channel (out_valid / out_stall / status / value_offset /
// value_length): exactly one transaction per packet, produced by its final
// octet. Status: found, not found, malformed, or shorter than the header.
// Config port (cfg_wr_en / cfg_index / cfg_data): index 0 is match_type,
// index 1 is match_skip; write only between packets.
// The result of a packet is registered: its last octet sits in the input
// register, then the result goes into the result register.
// Throughput: one octet per cycle without in_stall; the walk is a single
// small state update per octet between the input and result registers.
// Reset clears the walk, the config registers (both zero) and all valids.
// When the receiver stalls, the result holds; the input side keeps taking
// octets until the next packet's final octet also needs the result
// register, and only then raises in_stall.

module radius_attribute_finder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [11:0]                   value_offset,
	output logic [7:0]                    value_length,
	input  logic                          cfg_wr_en,
	input  logic [raf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import raf_pkg::*;

	// config registers
	logic [BYTE_W-1:0] match_type_q;
	logic [BYTE_W-1:0] match_skip_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	// result register
	logic              out_valid_q;
	res_t              res_q;

	logic  out_free;
	logic  s1_adv;
	step_t step;
	res_t  res;

	assign out_free = !out_valid_q || !out_stall;
	// stage 1 blocks only when it holds a final octet and the result is stuck
	assign s1_adv   = !(valid_s1 && last_s1 && !out_free);
	assign in_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_type_q <= '0;
			match_skip_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MATCH_TYPE: match_type_q <= cfg_data;
				REG_MATCH_SKIP: match_skip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign step.valid = valid_s1 && s1_adv;
	assign step.data  = data_s1;
	assign step.last  = last_s1;

	raf_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.match_type (match_type_q),
		.match_skip (match_skip_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step.valid && step.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step.valid && step.last)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign value_offset = res_q.offset;
	assign value_length = res_q.length;

	// input side stalls only behind a held final octet and a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// a fresh result comes only from a final octet in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1 && last_s1))
		else $error("result without a final octet");

	// offset and length are zero unless the attribute was found
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != ST_FOUND) |->
			(res_q.offset == '0 && res_q.length == '0))
		else $error("nonzero offset or length without a match");

endmodule
